@@ design/line_line_intersection_macros.svh @@
// assertion macros for the line_line_intersection block
// expects clk_i and rst_ni in the scope of use; empty under synthesis
`ifndef LINE_LINE_INTERSECTION_MACROS_SVH
`define LINE_LINE_INTERSECTION_MACROS_SVH

`ifndef SYNTHESIS

`define LLI_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("line_line_intersection: assertion failed");

`define LLI_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("line_line_intersection: forbidden condition");

`else

`define LLI_ASSERT(name, prop)

`define LLI_NEVER(name, expr)

`endif

`endif

@@ design/lli_pkg.sv @@
// shared types and constants for the line_line_intersection block
// no dependencies
`timescale 1ns / 1ps

package lli_pkg;

  localparam int OUT_WIDTH = 44;

  localparam logic [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
  localparam logic [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_POINT    = 2'd0,
    KIND_SAME     = 2'd1,
    KIND_DISJOINT = 2'd2
  } kind_e;

endpackage

@@ design/line_line_intersection.sv @@
// Classifies two lines, each given by two integer points, and returns their intersection point
// as signed fixed point with FRAC_BITS fraction bits, rounded to nearest, ties away from zero,
// saturated to 44 bits; parallel lines give kind same or disjoint with zero coordinates.
// The block is a fully pipelined datapath that accepts one item every cycle unless it is full
// and the output is stalled. It has seven stages of differences, cross products and magnitudes,
// one restoring divider stage per quotient bit (3*COORD_WIDTH + FRAC_BITS + 6 of them), and an
// output register.
// A stage holds its item only while every stage after it is full and the output is stalled,
// so any bubble lets input go on.
// Depends on lli_pkg and line_line_intersection_macros.svh.
`timescale 1ns / 1ps

`include "line_line_intersection_macros.svh"

module line_line_intersection #(
  parameter int COORD_WIDTH = 11,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]         ax0_i,
  input  logic signed [COORD_WIDTH-1:0]         ay0_i,
  input  logic signed [COORD_WIDTH-1:0]         ax1_i,
  input  logic signed [COORD_WIDTH-1:0]         ay1_i,
  input  logic signed [COORD_WIDTH-1:0]         bx0_i,
  input  logic signed [COORD_WIDTH-1:0]         by0_i,
  input  logic signed [COORD_WIDTH-1:0]         bx1_i,
  input  logic signed [COORD_WIDTH-1:0]         by1_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output lli_pkg::kind_e                        kind_o,
  output logic signed [lli_pkg::OUT_WIDTH-1:0]  cross_x_o,
  output logic signed [lli_pkg::OUT_WIDTH-1:0]  cross_y_o
);

  import lli_pkg::*;

  localparam int DFW = COORD_WIDTH + 1;
  localparam int PW  = 2 * DFW;
  localparam int CW  = PW + 1;
  localparam int NW  = COORD_WIDTH + CW + 2;
  localparam int DW  = NW + FRAC_BITS + 1;
  localparam int RW  = CW + 1;
  localparam int QW  = (DW > OUT_WIDTH + 1) ? DW : OUT_WIDTH + 1;

  localparam int S_DIF  = 0;
  localparam int S_PRD  = 1;
  localparam int S_CRS  = 2;
  localparam int S_MUL  = 3;
  localparam int S_NUM  = 4;
  localparam int S_ABS  = 5;
  localparam int S_DVD  = 6;
  localparam int S_DIV0 = 7;
  localparam int S_OUT  = S_DIV0 + DW;
  localparam int NS     = S_OUT + 1;

  // stage valids and load enables
  logic [NS-1:0] v_q;
  logic [NS-1:0] ld;
  logic [NS-1:0] v_in;

  for (genvar k = 0; k < NS; k++) begin : g_ld
    assign ld[k] = out_ready_i | ~(&v_q[NS-1:k]);
  end

  assign v_in = {v_q[NS-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (ld & v_in) | (~ld & v_q);
    end
  end

  assign in_ready_o  = ld[S_DIF];
  assign out_valid_o = v_q[S_OUT];

  // differences
  logic signed [DFW-1:0]         d1x_q, d1y_q, d2x_q, d2y_q, ex_q, ey_q, fx_q, fy_q;
  logic signed [COORD_WIDTH-1:0] x2_q, y2_q;

  always_ff @(posedge clk_i) begin
    if (ld[S_DIF]) begin
      d1x_q <= DFW'(ax1_i) - DFW'(ax0_i);
      d1y_q <= DFW'(ay1_i) - DFW'(ay0_i);
      d2x_q <= DFW'(bx1_i) - DFW'(bx0_i);
      d2y_q <= DFW'(by1_i) - DFW'(by0_i);
      ex_q  <= DFW'(ax1_i) - DFW'(bx1_i);
      ey_q  <= DFW'(ay1_i) - DFW'(by1_i);
      fx_q  <= DFW'(ax0_i) - DFW'(bx0_i);
      fy_q  <= DFW'(ay0_i) - DFW'(by0_i);
      x2_q  <= ax1_i;
      y2_q  <= ay1_i;
    end
  end

  // cross product terms
  logic signed [PW-1:0]          pd1_q, pd2_q, pt1_q, pt2_q, pc1_q, pc2_q;
  logic signed [DFW-1:0]         p_d1x_q, p_d1y_q;
  logic signed [COORD_WIDTH-1:0] p_x2_q, p_y2_q;

  always_ff @(posedge clk_i) begin
    if (ld[S_PRD]) begin
      pd1_q   <= PW'(d1x_q) * PW'(d2y_q);
      pd2_q   <= PW'(d1y_q) * PW'(d2x_q);
      pt1_q   <= PW'(ex_q) * PW'(d2y_q);
      pt2_q   <= PW'(ey_q) * PW'(d2x_q);
      pc1_q   <= PW'(fy_q) * PW'(d1x_q);
      pc2_q   <= PW'(fx_q) * PW'(d1y_q);
      p_d1x_q <= d1x_q;
      p_d1y_q <= d1y_q;
      p_x2_q  <= x2_q;
      p_y2_q  <= y2_q;
    end
  end

  // denominator, t and collinearity
  logic signed [CW-1:0]          den_q, t_q;
  logic                          coll_q;
  logic signed [DFW-1:0]         c_d1x_q, c_d1y_q;
  logic signed [COORD_WIDTH-1:0] c_x2_q, c_y2_q;

  always_ff @(posedge clk_i) begin
    if (ld[S_CRS]) begin
      den_q   <= CW'(pd1_q) - CW'(pd2_q);
      t_q     <= CW'(pt1_q) - CW'(pt2_q);
      coll_q  <= (pc1_q == pc2_q);
      c_d1x_q <= p_d1x_q;
      c_d1y_q <= p_d1y_q;
      c_x2_q  <= p_x2_q;
      c_y2_q  <= p_y2_q;
    end
  end

  // numerator products
  logic signed [NW-1:0] m1x_q, m2x_q, m1y_q, m2y_q;
  logic signed [CW-1:0] m_den_q;
  kind_e                m_kind_q;
  kind_e                m_kind_d;

  always_comb begin
    if (den_q == '0) begin
      m_kind_d = coll_q ? KIND_SAME : KIND_DISJOINT;
    end else begin
      m_kind_d = KIND_POINT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[S_MUL]) begin
      m1x_q    <= NW'(c_x2_q) * NW'(den_q);
      m2x_q    <= NW'(c_d1x_q) * NW'(t_q);
      m1y_q    <= NW'(c_y2_q) * NW'(den_q);
      m2y_q    <= NW'(c_d1y_q) * NW'(t_q);
      m_den_q  <= den_q;
      m_kind_q <= m_kind_d;
    end
  end

  // numerators
  logic signed [NW-1:0] numx_q, numy_q;
  logic signed [CW-1:0] n_den_q;
  kind_e                n_kind_q;

  always_ff @(posedge clk_i) begin
    if (ld[S_NUM]) begin
      numx_q   <= m1x_q - m2x_q;
      numy_q   <= m1y_q - m2y_q;
      n_den_q  <= m_den_q;
      n_kind_q <= m_kind_q;
    end
  end

  // magnitudes and signs
  logic [NW-1:0] ax_q, ay_q;
  logic [CW-1:0] adm_q;
  logic          a_negx_q, a_negy_q;
  kind_e         a_kind_q;

  always_ff @(posedge clk_i) begin
    if (ld[S_ABS]) begin
      ax_q     <= numx_q[NW-1] ? NW'(-numx_q) : NW'(numx_q);
      ay_q     <= numy_q[NW-1] ? NW'(-numy_q) : NW'(numy_q);
      adm_q    <= n_den_q[CW-1] ? CW'(-n_den_q) : CW'(n_den_q);
      a_negx_q <= numx_q[NW-1] ^ n_den_q[CW-1];
      a_negy_q <= numy_q[NW-1] ^ n_den_q[CW-1];
      a_kind_q <= n_kind_q;
    end
  end

  // rounded dividend over doubled divisor
  logic [DW-1:0] dvx_q, dvy_q;
  logic [RW-1:0] dvs_q;
  logic          b_negx_q, b_negy_q;
  kind_e         b_kind_q;

  always_ff @(posedge clk_i) begin
    if (ld[S_DVD]) begin
      dvx_q    <= (DW'(ax_q) << (FRAC_BITS + 1)) + DW'(adm_q);
      dvy_q    <= (DW'(ay_q) << (FRAC_BITS + 1)) + DW'(adm_q);
      dvs_q    <= {adm_q, 1'b0};
      b_negx_q <= a_negx_q;
      b_negy_q <= a_negy_q;
      b_kind_q <= a_kind_q;
    end
  end

  // restoring divider, one quotient bit per stage
  logic [RW-1:0] remx_q [DW];
  logic [RW-1:0] remy_q [DW];
  logic [DW-1:0] qdx_q  [DW];
  logic [DW-1:0] qdy_q  [DW];
  logic [RW-1:0] dv_q   [DW];
  logic [DW-1:0] negx_q;
  logic [DW-1:0] negy_q;
  kind_e         dkind_q [DW];

  for (genvar i = 0; i < DW; i++) begin : g_div
    logic [RW-1:0] rx_in, ry_in, dv_in;
    logic [DW-1:0] qx_in, qy_in;
    logic          nx_in, ny_in;
    kind_e         k_in;
    logic [RW:0]   shx, shy;
    logic          gex, gey;

    if (i == 0) begin : g_first
      assign rx_in = '0;
      assign ry_in = '0;
      assign qx_in = dvx_q;
      assign qy_in = dvy_q;
      assign dv_in = dvs_q;
      assign nx_in = b_negx_q;
      assign ny_in = b_negy_q;
      assign k_in  = b_kind_q;
    end else begin : g_next
      assign rx_in = remx_q[i-1];
      assign ry_in = remy_q[i-1];
      assign qx_in = qdx_q[i-1];
      assign qy_in = qdy_q[i-1];
      assign dv_in = dv_q[i-1];
      assign nx_in = negx_q[i-1];
      assign ny_in = negy_q[i-1];
      assign k_in  = dkind_q[i-1];
    end

    assign shx = {rx_in, qx_in[DW-1]};
    assign shy = {ry_in, qy_in[DW-1]};
    assign gex = (shx >= {1'b0, dv_in});
    assign gey = (shy >= {1'b0, dv_in});

    always_ff @(posedge clk_i) begin
      if (ld[S_DIV0+i]) begin
        remx_q[i]  <= gex ? RW'(shx - {1'b0, dv_in}) : shx[RW-1:0];
        remy_q[i]  <= gey ? RW'(shy - {1'b0, dv_in}) : shy[RW-1:0];
        qdx_q[i]   <= {qx_in[DW-2:0], gex};
        qdy_q[i]   <= {qy_in[DW-2:0], gey};
        dv_q[i]    <= dv_in;
        negx_q[i]  <= nx_in;
        negy_q[i]  <= ny_in;
        dkind_q[i] <= k_in;
      end
    end
  end

  // sign and saturation
  function automatic logic [OUT_WIDTH-1:0] sat_coord(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0]        qn;
    logic [OUT_WIDTH-1:0] r;
    qn = -q;
    if (neg) begin
      r = (q > QW'(OUT_MIN)) ? OUT_MIN : qn[OUT_WIDTH-1:0];
    end else begin
      r = (q > QW'(OUT_MAX)) ? OUT_MAX : q[OUT_WIDTH-1:0];
    end
    return r;
  endfunction

  logic signed [OUT_WIDTH-1:0] cx_q, cy_q;
  kind_e                       kind_q;
  logic        [OUT_WIDTH-1:0] cx_d, cy_d;

  always_comb begin
    if (dkind_q[DW-1] == KIND_POINT) begin
      cx_d = sat_coord(QW'(qdx_q[DW-1]), negx_q[DW-1]);
      cy_d = sat_coord(QW'(qdy_q[DW-1]), negy_q[DW-1]);
    end else begin
      cx_d = '0;
      cy_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[S_OUT]) begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      kind_q <= dkind_q[DW-1];
    end
  end

  assign kind_o    = kind_q;
  assign cross_x_o = cx_q;
  assign cross_y_o = cy_q;

  `LLI_ASSERT(a_item_enters, in_valid_i && in_ready_o |=> v_q[S_DIF])
  `LLI_ASSERT(a_stall_only_full, !in_ready_o |-> (&v_q) && !out_ready_i)
  `LLI_NEVER(a_nonpoint_zero, out_valid_o && (kind_o != KIND_POINT) && ((cross_x_o != '0) || (cross_y_o != '0)))

endmodule
